### rtl/cnir_pkg.sv
// ----------------------------------------------------------------------------
// cnir_pkg: shared types and constants
// Payload structs, controller/datapath command and status bundles, and
// table sizing for the circular nearest-in-range search.
// ----------------------------------------------------------------------------
package cnir_pkg;

  localparam int TABLE_DEPTH = 512;
  localparam int IDX_W       = 9;
  localparam int LEN_W       = 10;
  localparam int VAL_W       = 32;
  localparam int DIST_W      = 11;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(TABLE_DEPTH);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic [IDX_W-1:0]        start_index;
    logic signed [VAL_W-1:0] range_low;
    logic signed [VAL_W-1:0] range_high;
  } in_item_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] step_distance;
    logic                     match_found;
  } out_item_t;

  typedef struct packed {
    logic write;
    logic load_query;
    logic issue;
    logic capture;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic start_oob;
    logic issue_last;
    logic eval_stop;
    logic out_free;
  } status_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    res = len;
    if (len == '0) begin
      res = LEN_W'(1);
    end else if (len > LEN_W'(TABLE_DEPTH)) begin
      res = LEN_W'(TABLE_DEPTH);
    end
    return res;
  endfunction

endpackage

### rtl/cnir_ctrl.sv
// ----------------------------------------------------------------------------
// cnir_ctrl: search controller
// Sequences write transfers, query setup, the ring walk, and the hand-off
// of a finished answer to the output register.
// ----------------------------------------------------------------------------
module cnir_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_stall,
  input  cnir_pkg::status_t status,
  output cnir_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ISSUE  = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       in_xfer;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_op == cnir_pkg::OP_WRITE) begin
          cmd.write = 1'b1;
        end else if (in_xfer && in_op == cnir_pkg::OP_QUERY) begin
          cmd.load_query = 1'b1;
          state_nxt      = status.start_oob ? ST_RESULT : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (status.eval_stop) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_RESULT;
        end else begin
          cmd.issue = 1'b1;
          if (status.issue_last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        cmd.capture = 1'b1;
        state_nxt   = ST_RESULT;
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // the last lookup always resolves in the cycle after it is issued
  a_drain_stops: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> status.eval_stop)
    else $error("drain state without a finished evaluation");

endmodule

### rtl/cnir_dp.sv
// ----------------------------------------------------------------------------
// cnir_dp: search datapath
// Value table with two registered read ports, ring pointers, range compare
// stage, answer register and output register.
// ----------------------------------------------------------------------------
module cnir_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [cnir_pkg::LEN_W-1:0]        cfg_wr_data,
  input  cnir_pkg::in_item_t                in_data,
  input  cnir_pkg::cmd_t                    cmd,
  output cnir_pkg::status_t                 status,
  output logic                              out_valid,
  output cnir_pkg::out_item_t               out_data,
  input  logic                              out_stall
);

  logic [cnir_pkg::VAL_W-1:0] value_mem_r [cnir_pkg::TABLE_DEPTH];

  logic [cnir_pkg::LEN_W-1:0]        len_r;
  logic [cnir_pkg::LEN_W-1:0]        len_eff_r;
  logic [cnir_pkg::LEN_W-1:0]        len_cur;
  logic [cnir_pkg::IDX_W-1:0]        fwd_r;
  logic [cnir_pkg::IDX_W-1:0]        bwd_r;
  logic [cnir_pkg::IDX_W-1:0]        k_r;
  logic [cnir_pkg::IDX_W-1:0]        kd_r;
  logic                              eval_v_r;
  logic signed [cnir_pkg::VAL_W-1:0] lo_r;
  logic signed [cnir_pkg::VAL_W-1:0] hi_r;
  logic signed [cnir_pkg::VAL_W-1:0] rd_f_r;
  logic signed [cnir_pkg::VAL_W-1:0] rd_b_r;
  logic signed [cnir_pkg::DIST_W-1:0] res_dist_r;
  logic                              res_found_r;
  logic                              out_valid_r;
  cnir_pkg::out_item_t               out_data_r;

  logic [cnir_pkg::IDX_W-1:0]  fwd_nxt;
  logic [cnir_pkg::IDX_W-1:0]  bwd_nxt;
  logic [cnir_pkg::LEN_W-1:0]  last_k;
  logic                        hit_f;
  logic                        hit_b;
  logic signed [cnir_pkg::DIST_W-1:0] eval_dist;

  assign len_cur = cnir_pkg::eff_len(len_r);
  assign last_k  = len_eff_r - cnir_pkg::LEN_W'(1);

  always_comb begin
    if ({1'b0, fwd_r} + cnir_pkg::LEN_W'(1) == len_eff_r) begin
      fwd_nxt = '0;
    end else begin
      fwd_nxt = fwd_r + cnir_pkg::IDX_W'(1);
    end
    if (bwd_r == '0) begin
      bwd_nxt = last_k[cnir_pkg::IDX_W-1:0];
    end else begin
      bwd_nxt = bwd_r - cnir_pkg::IDX_W'(1);
    end
  end

  assign hit_f = (rd_f_r >= lo_r) && (rd_f_r <= hi_r);
  assign hit_b = (rd_b_r >= lo_r) && (rd_b_r <= hi_r) && (kd_r != '0);

  always_comb begin
    if (hit_f) begin
      eval_dist = $signed({2'b00, kd_r});
    end else if (hit_b) begin
      eval_dist = $signed(cnir_pkg::DIST_W'(0) - {2'b00, kd_r});
    end else begin
      eval_dist = $signed({1'b0, len_eff_r});
    end
  end

  assign status.start_oob  = ({1'b0, in_data.start_index} >= len_cur);
  assign status.issue_last = ({1'b0, k_r} == last_k);
  assign status.eval_stop  = eval_v_r && (hit_f || hit_b || {1'b0, kd_r} == last_k);
  assign status.out_free   = !out_valid_r || !out_stall;

  // table write port
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      value_mem_r[in_data.entry_index] <= in_data.entry_value;
    end
  end

  // table read ports
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_f_r <= value_mem_r[fwd_r];
      rd_b_r <= value_mem_r[bwd_r];
      kd_r   <= k_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= cnir_pkg::LEN_RESET;
      eval_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
      eval_v_r <= cmd.issue;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      len_eff_r   <= len_cur;
      fwd_r       <= in_data.start_index;
      bwd_r       <= in_data.start_index;
      k_r         <= '0;
      lo_r        <= in_data.range_low;
      hi_r        <= in_data.range_high;
      res_dist_r  <= $signed({1'b0, len_cur});
      res_found_r <= 1'b0;
    end else begin
      if (cmd.issue) begin
        fwd_r <= fwd_nxt;
        bwd_r <= bwd_nxt;
        k_r   <= k_r + cnir_pkg::IDX_W'(1);
      end
      if (cmd.capture) begin
        res_dist_r  <= eval_dist;
        res_found_r <= hit_f || hit_b;
      end
    end
    if (cmd.load_out) begin
      out_data_r.step_distance <= res_dist_r;
      out_data_r.match_found   <= res_found_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> ({1'b0, fwd_r} < len_eff_r) && ({1'b0, bwd_r} < len_eff_r))
    else $error("ring pointer outside effective length");

  a_step_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    eval_v_r |-> ({1'b0, kd_r} < len_eff_r))
    else $error("evaluated step beyond effective length");

  a_miss_is_length: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture && !(hit_f || hit_b) |=> res_dist_r == $signed({1'b0, len_eff_r}))
    else $error("miss answer differs from effective length");

endmodule

### rtl/circular_nearest_in_range.sv
// ----------------------------------------------------------------------------
// circular_nearest_in_range: top level
// A write transfer stores one entry. A query walks the ring one step per
// cycle, reading the forward and backward entries together through the two
// read ports of the value table; an answer passes from the answer register
// to the output register, and the next transfer is taken once the answer
// moves to the output register. A query whose start index is at or beyond
// the effective length answers as a miss without walking the ring. No
// clearing pass runs after reset.
// ----------------------------------------------------------------------------
module circular_nearest_in_range (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [cnir_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  cnir_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output cnir_pkg::out_item_t        out_data
);

  cnir_pkg::cmd_t    cmd;
  cnir_pkg::status_t status;

  cnir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  cnir_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .out_stall   (out_stall)
  );

endmodule
